// File: rtl/core/utf8v_pkg.sv
// Package for the UTF-8 validator: field widths, byte class constants and
// the rule code for the second byte of a sequence. It has no dependencies.
package utf8v_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned PendingW = 2;

    // Lead byte prefixes, compared against the top bits of the byte.
    localparam logic [2:0] Lead2Tag  = 3'h6;   // 110xxxxx
    localparam logic [3:0] Lead3Tag  = 4'hE;   // 1110xxxx
    localparam logic [4:0] Lead4Tag  = 5'h1E;  // 11110xxx
    localparam logic [1:0] FollowTag = 2'h2;   // 10xxxxxx

    // Limits that reject overlong forms.
    localparam logic [ByteW-1:0] AsciiTop  = 8'h80;
    localparam logic [ByteW-1:0] Lead2Min  = 8'hC2;
    localparam logic [ByteW-1:0] LeadE0    = 8'hE0;
    localparam logic [ByteW-1:0] AfterE0   = 8'hA0;
    localparam logic [ByteW-1:0] LeadF0    = 8'hF0;
    localparam logic [ByteW-1:0] AfterF0   = 8'h90;

    localparam logic [PendingW-1:0] Pend0 = 2'd0;
    localparam logic [PendingW-1:0] Pend1 = 2'd1;
    localparam logic [PendingW-1:0] Pend2 = 2'd2;
    localparam logic [PendingW-1:0] Pend3 = 2'd3;

    // Extra limit on the byte that follows the lead.
    typedef enum logic [1:0] {
        RULE_NONE = 2'd0,
        RULE_E0   = 2'd1,
        RULE_F0   = 2'd2
    } t_rule;

endpackage

// File: rtl/core/utf8v_if.sv
// Stream interfaces of the UTF-8 validator: the byte channel in and the
// verdict channel out, each with valid/ready. Depends on utf8v_pkg.
interface utf8v_byte_if import utf8v_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_res_if;
    logic valid;
    logic ready;
    logic valid_res;
    logic done_res;

    modport source (output valid, output valid_res, output done_res, input ready);
    modport sink   (input valid, input valid_res, input done_res, output ready);
endinterface

// File: rtl/core/utf8_encoding_validator.sv
// UTF-8 encoding validator, top level. Depends on utf8v_pkg and on the
// stream interfaces in utf8v_if.sv.

// The block takes one byte of a string per item and returns one verdict
// item for each byte. The verdict says whether the string is well formed
// UTF-8 so far; on the item that carries last_byte it is final, and it is
// then also cleared if a multi-byte sequence is still open. An error is
// sticky until the end of the string, after which the next byte starts a
// new string. Overlong two-byte leads (below C2) and overlong three- and
// four-byte forms (E0 followed by a byte below A0, F0 followed by a byte
// below 90) are rejected; surrogates are not checked and leads F4 to F7
// pass. The state update is a single small step from the current state and
// the byte, so a byte can be accepted in every cycle unless the input is
// stalled. A verdict is registered in the result register, or in the skid
// register while the result register holds one not being taken. With both
// output registers the input stays ready while one verdict waits; the input
// stalls only when both hold a verdict that has not been taken.
module utf8_encoding_validator
    import utf8v_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    utf8v_byte_if.sink   i_in,
    utf8v_res_if.source  o_res
);

    // Scan state for the current string.
    logic [PendingW-1:0] r_pending, n_pending;
    t_rule               r_rule,    n_rule;
    logic                r_err,     n_err;

    // Output register and skid register.
    logic r_out_vld, r_out_ok, r_out_done;
    logic r_skid_vld, r_skid_ok, r_skid_done;

    logic             push;
    logic             pop;
    logic             res_ok;
    logic [ByteW-1:0] c;

    assign c          = i_in.data_byte;
    assign i_in.ready = !r_skid_vld;
    assign push       = i_in.valid && i_in.ready;
    assign pop        = r_out_vld && o_res.ready;

    // Next scan state and the verdict for the incoming byte.
    always_comb begin
        logic [PendingW-1:0] step_pending;
        t_rule               step_rule;
        logic                step_err;

        step_pending = r_pending;
        step_rule    = r_rule;
        step_err     = r_err;

        if (!r_err) begin
            if (r_pending == Pend0) begin
                // Lead byte.
                if (c < AsciiTop) begin
                    step_err = 1'b0;
                end else if (c[7:5] == Lead2Tag) begin
                    if (c < Lead2Min) begin
                        step_err = 1'b1;
                    end else begin
                        step_pending = Pend1;
                    end
                end else if (c[7:4] == Lead3Tag) begin
                    step_pending = Pend2;
                    step_rule    = (c == LeadE0) ? RULE_E0 : RULE_NONE;
                end else if (c[7:3] == Lead4Tag) begin
                    step_pending = Pend3;
                    step_rule    = (c == LeadF0) ? RULE_F0 : RULE_NONE;
                end else begin
                    step_err = 1'b1;
                end
            end else begin
                // Continuation byte, with the overlong limit on the first one.
                if (c[7:6] != FollowTag) begin
                    step_err = 1'b1;
                end else if (r_rule == RULE_E0 && c < AfterE0) begin
                    step_err = 1'b1;
                end else if (r_rule == RULE_F0 && c < AfterF0) begin
                    step_err = 1'b1;
                end else begin
                    step_rule    = RULE_NONE;
                    step_pending = r_pending - Pend1;
                end
            end
        end

        res_ok = !step_err && !(i_in.last_byte && step_pending != Pend0);

        // The end of a string returns the scan state to its start.
        if (i_in.last_byte) begin
            n_pending = Pend0;
            n_rule    = RULE_NONE;
            n_err     = 1'b0;
        end else begin
            n_pending = step_pending;
            n_rule    = step_rule;
            n_err     = step_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= Pend0;
            r_rule    <= RULE_NONE;
            r_err     <= 1'b0;
        end else if (push) begin
            r_pending <= n_pending;
            r_rule    <= n_rule;
            r_err     <= n_err;
        end
    end

    // Output side: the skid register fills only when a new verdict arrives
    // while the output register holds one that is not being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= push;
                end
            end else if (!r_out_vld) begin
                r_out_vld <= push;
            end else if (push) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_vld) begin
            r_out_ok   <= r_skid_ok;
            r_out_done <= r_skid_done;
        end else if (push && (pop || !r_out_vld)) begin
            r_out_ok   <= res_ok;
            r_out_done <= i_in.last_byte;
        end
        if (push && r_out_vld && !pop) begin
            r_skid_ok   <= res_ok;
            r_skid_done <= i_in.last_byte;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.valid_res = r_out_ok;
    assign o_res.done_res  = r_out_done;

endmodule
